// ===== rtl/core/fud_pkg.sv =====
// Shared types, character codes and helpers for the form-urlencoded decoder.
// No dependencies; used by fud_front, fud_queue, fud_back and the top level.
`timescale 1ns / 1ps

package fud_pkg;

  // Special characters of the encoding
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Most results one input item can cause
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2
  } kind_t;

  // Escape progress in value phase
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       kept;
  } res_t;

  // All results of one input item, oldest in entry 0
  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    res_t [MAX_RES-1:0]      ent;
  } bundle_t;

  // Hex digit value; anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/fud_front.sv =====
// Front end: accepts characters, tracks key/value/escape state and builds
// the result bundle for each item. Depends on fud_pkg.
`timescale 1ns / 1ps

module fud_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char,
  input  logic                in_char_valid,
  input  logic                in_end_of_text,
  input  logic                push,
  input  logic                q_full,
  output logic                q_push,
  output fud_pkg::bundle_t    q_bundle
);

  logic                val_r,  val_nxt;
  fud_pkg::esc_t       esc_r,  esc_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                key_r,  key_nxt;
  fud_pkg::bundle_t    bnd;
  logic                accept;

  assign accept = push && !q_full;

  // Decode one item into next state and up to three results
  always_comb begin
    logic [7:0]              c;
    logic [fud_pkg::CNT_W-1:0] n;
    val_nxt  = val_r;
    esc_nxt  = esc_r;
    held_nxt = held_r;
    key_nxt  = key_r;
    bnd      = '0;
    n        = '0;
    c        = (in_char == fud_pkg::CH_PLUS) ? fud_pkg::CH_SPACE : in_char;

    if (in_char_valid) begin
      if (!val_r) begin
        if (c == fud_pkg::CH_EQUALS) begin
          val_nxt = 1'b1;
        end else begin
          bnd.ent[n] = '{data: c, kind: fud_pkg::KIND_KEY, kept: 1'b0};
          n = n + 1'b1;
          key_nxt = 1'b1;
        end
      end else if (c == fud_pkg::CH_AMP) begin
        // Flush an unfinished escape, then close the pair
        if (esc_r != fud_pkg::ESC_NONE) begin
          bnd.ent[n] = '{data: fud_pkg::CH_PERCENT, kind: fud_pkg::KIND_VALUE, kept: 1'b0};
          n = n + 1'b1;
        end
        if (esc_r == fud_pkg::ESC_DIGIT) begin
          bnd.ent[n] = '{data: held_r, kind: fud_pkg::KIND_VALUE, kept: 1'b0};
          n = n + 1'b1;
        end
        bnd.ent[n] = '{data: 8'h00, kind: fud_pkg::KIND_PAIR_END, kept: 1'b1};
        n = n + 1'b1;
        esc_nxt  = fud_pkg::ESC_NONE;
        held_nxt = 8'h00;
        val_nxt  = 1'b0;
        key_nxt  = 1'b0;
      end else begin
        unique case (esc_r)
          fud_pkg::ESC_NONE: begin
            if (c == fud_pkg::CH_PERCENT) begin
              esc_nxt = fud_pkg::ESC_PCT;
            end else begin
              bnd.ent[n] = '{data: c, kind: fud_pkg::KIND_VALUE, kept: 1'b0};
              n = n + 1'b1;
            end
          end
          fud_pkg::ESC_PCT: begin
            held_nxt = c;
            esc_nxt  = fud_pkg::ESC_DIGIT;
          end
          fud_pkg::ESC_DIGIT: begin
            bnd.ent[n] = '{data: {fud_pkg::hex_value(held_r), fud_pkg::hex_value(c)},
                           kind: fud_pkg::KIND_VALUE, kept: 1'b0};
            n = n + 1'b1;
            esc_nxt  = fud_pkg::ESC_NONE;
            held_nxt = 8'h00;
          end
          default: begin
            esc_nxt = fud_pkg::ESC_NONE;
          end
        endcase
      end
    end

    // End of text: close an open pair, then return to reset state
    if (in_end_of_text) begin
      if (val_nxt || key_nxt) begin
        if (esc_nxt != fud_pkg::ESC_NONE) begin
          bnd.ent[n] = '{data: fud_pkg::CH_PERCENT, kind: fud_pkg::KIND_VALUE, kept: 1'b0};
          n = n + 1'b1;
        end
        if (esc_nxt == fud_pkg::ESC_DIGIT) begin
          bnd.ent[n] = '{data: held_nxt, kind: fud_pkg::KIND_VALUE, kept: 1'b0};
          n = n + 1'b1;
        end
        bnd.ent[n] = '{data: 8'h00, kind: fud_pkg::KIND_PAIR_END, kept: key_nxt};
        n = n + 1'b1;
      end
      val_nxt  = 1'b0;
      esc_nxt  = fud_pkg::ESC_NONE;
      held_nxt = 8'h00;
      key_nxt  = 1'b0;
    end
    bnd.cnt = n;
  end

  // Hand non-empty bundles to the queue
  assign q_push   = accept && (bnd.cnt != '0);
  assign q_bundle = bnd;

  // Advance state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= 1'b0;
      esc_r  <= fud_pkg::ESC_NONE;
      held_r <= 8'h00;
      key_r  <= 1'b0;
    end else if (accept) begin
      val_r  <= val_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
      key_r  <= key_nxt;
    end
  end

  // An escape is only ever pending in value phase
  a_esc_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    !val_r |-> esc_r == fud_pkg::ESC_NONE)
    else $error("escape pending in key phase");

  // Held digit is cleared whenever no digit is held
  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r != fud_pkg::ESC_DIGIT |-> held_r == 8'h00)
    else $error("stale held digit");

  // Every queued bundle carries at least one result
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_bundle.cnt != '0 && q_bundle.cnt <= 2'(fud_pkg::MAX_RES))
    else $error("bad bundle count");

endmodule

// ===== rtl/core/fud_queue.sv =====
// Short register queue of result bundles between front and back end.
// Depends on fud_pkg.
`timescale 1ns / 1ps

module fud_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  fud_pkg::bundle_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output fud_pkg::bundle_t  rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fud_pkg::bundle_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  // Advance pointers with wrap at DEPTH
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'(1) && do_rd && !do_wr |=> empty)
    else $error("queue not empty after last read");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wp_r == rp_r)
    else $error("pointers differ while empty");

endmodule

// ===== rtl/core/fud_back.sv =====
// Back end: walks the results of the head bundle one per pop and marks the
// last one of each item. Depends on fud_pkg.
`timescale 1ns / 1ps

module fud_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fud_pkg::bundle_t  q_head,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic [1:0]        out_kind,
  output logic              out_pair_kept,
  output logic              out_run_last
);

  logic [fud_pkg::CNT_W-1:0] sub_r, sub_nxt;
  fud_pkg::res_t             cur;
  logic                      at_last;
  logic                      take;

  assign empty   = q_empty;
  assign take    = pop && !q_empty;
  assign cur     = q_head.ent[sub_r];
  assign at_last = (sub_r == q_head.cnt - 1'b1);

  assign out_byte      = cur.data;
  assign out_kind      = 2'(cur.kind);
  assign out_pair_kept = cur.kept;
  assign out_run_last  = at_last;

  // Release the bundle after its last result
  assign q_pop = take && at_last;

  always_comb begin
    sub_nxt = sub_r;
    if (take) begin
      sub_nxt = at_last ? '0 : sub_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> sub_r < q_head.cnt)
    else $error("result index beyond bundle");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> sub_r == '0)
    else $error("result index left over while empty");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !at_last |=> sub_r == $past(sub_r) + 1'b1)
    else $error("result index did not advance");

endmodule

// ===== rtl/core/form_urlencoded_decoder_unit.sv =====
// Top level of the form-urlencoded decoder: front end, bundle queue and
// back end. Depends on fud_pkg, fud_front, fud_queue and fud_back.
//
//   channel  handshake      accepted when      payload
//   input    push / full    push && !full      in_char, in_char_valid, in_end_of_text
//   result   empty / pop    pop && !empty      out_byte, out_kind, out_pair_kept,
//                                              out_run_last
//
// One character is taken per cycle while the bundle queue has room.
// An item yields zero to three results; the back end sends one per cycle
// while pop is high, so an item with several results takes one pop for each.
// Results of an accepted item pass through the registered bundle queue.
// Synchronous active-low reset clears phase, escape state and the queue.
// A stalled result side fills the QDEPTH-entry queue, then raises full.
`timescale 1ns / 1ps

module form_urlencoded_decoder_unit #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char,
  input  logic        in_char_valid,
  input  logic        in_end_of_text,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_pair_kept,
  output logic        out_run_last,
  output logic        empty,
  input  logic        pop
);

  logic              q_push;
  fud_pkg::bundle_t  q_wr;
  fud_pkg::bundle_t  q_head;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  assign full = q_full;

  fud_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_char        (in_char),
    .in_char_valid  (in_char_valid),
    .in_end_of_text (in_end_of_text),
    .push           (push),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_bundle       (q_wr)
  );

  fud_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  fud_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_pair_kept (out_pair_kept),
    .out_run_last  (out_run_last)
  );

endmodule

// ===== verif/form_urlencoded_decoder_unit_tb.sv =====
// Self-checking testbench for the form-urlencoded decoder: directed and random text
// through the push/full input queue, results checked against a built-in predictor.
// Depends on fud_pkg and form_urlencoded_decoder_unit.
`timescale 1ns / 1ps

module form_urlencoded_decoder_unit_tb;

  // One expected decoder output
  typedef struct {
    logic [7:0]       data;
    fud_pkg::kind_t   kind;
    logic             kept;
    logic             last;
  } dec_res_t;

  // Decoder predictor and store of expected results
  class fud_scoreboard;
    bit              value_phase = 1'b0;
    fud_pkg::esc_t   esc = fud_pkg::ESC_NONE;
    logic [7:0]      held = 8'd0;
    bit              key_seen = 1'b0;
    dec_res_t        expected_q[$];
    int              n_err = 0;
    int              n_checked = 0;

    function logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - 8'h30);
      if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
      if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
      return 4'd0;
    endfunction

    function void add(input logic [7:0] d, input fud_pkg::kind_t k, input logic kept);
      dec_res_t r;
      r.data = d;
      r.kind = k;
      r.kept = kept;
      r.last = 1'b0;
      expected_q = {expected_q, r};
    endfunction

    // Emit a pending escape literally and clear it
    function void flush_escape();
      if (esc != fud_pkg::ESC_NONE) add(fud_pkg::CH_PERCENT, fud_pkg::KIND_VALUE, 1'b0);
      if (esc == fud_pkg::ESC_DIGIT) add(held, fud_pkg::KIND_VALUE, 1'b0);
      esc = fud_pkg::ESC_NONE;
      held = 8'd0;
    endfunction

    // Predict the results of one accepted input transaction
    function void note_item(input logic [7:0] ch, input logic valid, input logic eot);
      int         first;
      logic [7:0] c;
      first = expected_q.size();
      c = ch;
      if (valid) begin
        if (c == fud_pkg::CH_PLUS) c = fud_pkg::CH_SPACE;
        if (!value_phase) begin
          if (c == fud_pkg::CH_EQUALS) begin
            value_phase = 1'b1;
          end else begin
            add(c, fud_pkg::KIND_KEY, 1'b0);
            key_seen = 1'b1;
          end
        end else if (c == fud_pkg::CH_AMP) begin
          flush_escape();
          add(8'd0, fud_pkg::KIND_PAIR_END, 1'b1);
          value_phase = 1'b0;
          key_seen = 1'b0;
        end else if (esc == fud_pkg::ESC_NONE) begin
          if (c == fud_pkg::CH_PERCENT) esc = fud_pkg::ESC_PCT;
          else add(c, fud_pkg::KIND_VALUE, 1'b0);
        end else if (esc == fud_pkg::ESC_PCT) begin
          held = c;
          esc = fud_pkg::ESC_DIGIT;
        end else begin
          add({nibble_of(held), nibble_of(c)}, fud_pkg::KIND_VALUE, 1'b0);
          esc = fud_pkg::ESC_NONE;
          held = 8'd0;
        end
      end
      if (eot) begin
        if (value_phase || key_seen) begin
          flush_escape();
          add(8'd0, fud_pkg::KIND_PAIR_END, key_seen);
        end
        value_phase = 1'b0;
        esc = fud_pkg::ESC_NONE;
        held = 8'd0;
        key_seen = 1'b0;
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_result(input logic [7:0] d, input logic [1:0] k,
                               input logic kept, input logic last);
      dec_res_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR %0t: unexpected result byte=%02h kind=%0d kept=%0b last=%0b",
                   $realtime, d, k, kept, last);
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data || k !== e.kind || kept !== e.kept || last !== e.last) begin
        n_err++;
        if (n_err <= 10)
          $display({"ERROR %0t: exp byte=%02h kind=%0d kept=%0b last=%0b, ",
                    "got byte=%02h kind=%0d kept=%0b last=%0b"},
                   $realtime, e.data, e.kind, e.kept, e.last, d, k, kept, last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic [7:0] in_char = 8'd0;
  logic       in_char_valid = 1'b0;
  logic       in_end_of_text = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_pair_kept;
  logic       out_run_last;
  logic       empty;
  logic       pop = 1'b0;

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_left = 0;
  int n_sent = 0;

  fud_scoreboard sb = new();

  form_urlencoded_decoder_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_char       (in_char),
    .in_char_valid (in_char_valid),
    .in_end_of_text(in_end_of_text),
    .push          (push),
    .full          (full),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_pair_kept (out_pair_kept),
    .out_run_last  (out_run_last),
    .empty         (empty),
    .pop           (pop)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_item(in_char, in_char_valid, in_end_of_text);
      if (pop && !empty) sb.check_result(out_byte, out_kind, out_pair_kept, out_run_last);
    end
  end

  // Drive pop; hold it low while hold_left counts down when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
    end else if (hold_left > 0) begin
      pop = 1'b0;
      hold_left--;
    end else begin
      pop = ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Offer one item; return at the falling edge after it is accepted, push still high
  task automatic send_item(input logic [7:0] c, input logic v, input logic e);
    while ($urandom_range(0, 99) < snd_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    in_char = c;
    in_char_valid = v;
    in_end_of_text = e;
    push = 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    if (v || e) n_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, eot_last && i == s.len() - 1);
  endtask

  // Stop offering and wait until every expected result is out
  task automatic drain();
    push = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_hex();
    string hx;
    hx = "0123456789abcdefABCDEF";
    return hx[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_key_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = fud_pkg::CH_PLUS;
      1: c = fud_pkg::CH_AMP;
      2: c = fud_pkg::CH_PERCENT;
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == fud_pkg::CH_EQUALS) c = "k";
      end
    endcase
    return c;
  endfunction

  // Send a record of pairs with random content and a random ending
  task automatic send_record();
    logic [7:0] txt[$];
    logic [7:0] c;
    int         npairs;
    int         mode;
    npairs = $urandom_range(1, 3);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) txt = {txt, fud_pkg::CH_AMP};
      repeat ($urandom_range(0, 4)) txt = {txt, rand_key_char()};
      if ($urandom_range(0, 9) != 0) txt = {txt, fud_pkg::CH_EQUALS};
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            txt = {txt, fud_pkg::CH_PERCENT, rand_hex(), rand_hex()};
          end
          2: begin
            txt = {txt, fud_pkg::CH_PERCENT, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255))};
          end
          3: txt = {txt, ($urandom_range(0, 1) ? fud_pkg::CH_PLUS : fud_pkg::CH_EQUALS)};
          default: begin
            c = 8'($urandom_range(0, 255));
            if (c == fud_pkg::CH_AMP || c == fud_pkg::CH_PERCENT) c = "v";
            txt = {txt, c};
          end
        endcase
      end
    end
    mode = $urandom_range(0, 9);
    // Leave an escape unfinished before the end of text
    if (mode == 8) begin
      txt = {txt, fud_pkg::CH_PERCENT};
      if ($urandom_range(0, 1)) txt = {txt, rand_hex()};
    end
    for (int i = 0; i < txt.size(); i++)
      send_item(txt[i], 1'b1, (mode <= 5 || mode == 8) && i == txt.size() - 1);
    if (mode == 6 || mode == 7 || txt.size() == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic run_random(input int target);
    while (n_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
                  $urandom_range(0, 7) == 0);
      else
        send_record();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: byte extremes, plus as space, escapes with non-hex digits
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("=%", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("f+%A+&", 1'b0);
    // Empty key closed by ampersand is kept
    send_text("=v&", 1'b0);
    // Unfinished escape flushed at the ampersand
    send_text("k=%z&", 1'b0);
    // Unfinished escape flushed at end of text
    send_text("q=%", 1'b1);
    // Empty key at end of text gives a pair end with kept clear
    send_text("=", 1'b1);
    // Empty item, then an end marker with no pair open
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();

    // Light sender idling, heavy receiver idling
    snd_idle = 12;
    rcv_idle = 61;
    run_random(n_sent + 85);
    drain();

    // Heavy sender idling, light receiver idling
    snd_idle = 61;
    rcv_idle = 12;
    run_random(n_sent + 85);
    drain();

    // No idling; hold the receiver off so the queue fills and full rises
    snd_idle = 0;
    rcv_idle = 0;
    hold_left = 120;
    run_random(n_sent + 95);
    drain();

    repeat (10) @(negedge clk);
    sb.n_err += sb.expected_q.size();
    $display("Sent %0d characters and end markers, checked %0d decoded results,",
             n_sent, sb.n_checked);
    $display("under idling on both sides and a long result-side hold-off.");
    if (sb.n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
